// File: src/id3_pkg.sv
// Shared types, codes and constants of the ID3v2 tag frame splitter.
package id3_pkg;

  typedef enum logic [2:0] {
    PH_TAG_HDR   = 3'd0,
    PH_FRAME_HDR = 3'd1,
    PH_PAYLOAD   = 3'd2,
    PH_PAST      = 3'd3,
    PH_REJECT    = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_TAG_HDR   = 3'd0;
  localparam logic [2:0] KIND_FRAME_HDR = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd2;
  localparam logic [2:0] KIND_PAST      = 3'd3;
  localparam logic [2:0] KIND_REJECT    = 3'd4;

  localparam logic [7:0] CHAR_I        = 8'h49;
  localparam logic [7:0] CHAR_D        = 8'h44;
  localparam logic [7:0] CHAR_3        = 8'h33;
  localparam logic [7:0] CHAR_T        = 8'h54;
  localparam logic [7:0] VERSION_MAJOR = 8'h04;

  localparam logic [3:0] POS_ID0       = 4'd0;
  localparam logic [3:0] POS_ID1       = 4'd1;
  localparam logic [3:0] POS_ID2       = 4'd2;
  localparam logic [3:0] POS_VERSION   = 4'd3;
  localparam logic [3:0] POS_TAG_LEN   = 4'd6;
  localparam logic [3:0] POS_SIZE      = 4'd4;
  localparam logic [3:0] POS_FLAGS     = 4'd8;
  localparam logic [3:0] POS_HDR_LAST  = 4'd9;

  localparam logic [28:0] CONSUMED_LIMIT = 29'h1000_0000;
  localparam logic [32:0] FRAME_HDR_LEN  = 33'd10;

  // Register index of the configuration port.
  localparam logic REG_FRAME_SIZE_MODE = 1'b0;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_value;
    logic [31:0] frame_name;
    logic [31:0] frame_length;
    logic [31:0] payload_offset;
    logic        frame_end;
    logic        text_frame;
    logic [27:0] tag_length;
  } result_t;

endpackage

// File: src/id3_cfg.sv
// Configuration register file with its APB-style access port.
module id3_cfg import id3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        frame_size_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAME_SIZE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size_mode <= 1'b0;
    end else if (wr_en) begin
      frame_size_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAME_SIZE_MODE) begin
      prdata = {31'b0, frame_size_mode};
    end
  end

endmodule

// File: src/id3_parser.sv
// Parse state of the tag and the classification of one byte.
module id3_parser import id3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       frame_size_mode,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [3:0]  header_position, header_position_next;
  logic        header_ok, header_ok_next;
  logic [27:0] tag_len_reg, tag_len_reg_next;
  logic [28:0] consumed_count, consumed_count_next;
  logic [31:0] current_id, current_id_next;
  logic [31:0] current_size, current_size_next;
  logic [31:0] payload_count, payload_count_next;

  logic        start_past;
  logic        last_payload;
  logic [31:0] size_base;
  logic [32:0] consumed_sum;

  // A frame may only start while the consumed bytes stay below the tag size and its first byte is not zero.
  assign start_past = (header_position == POS_ID0) &&
                      ((consumed_count >= {1'b0, tag_len_reg}) || (data_byte == 8'h00));
  assign last_payload = (payload_count == (current_size - 32'd1));
  assign size_base    = (header_position == POS_ID0) ? 32'd0 : current_size;
  assign consumed_sum = {4'b0, consumed_count} + FRAME_HDR_LEN + {1'b0, current_size_next};

  always_comb begin
    phase_next           = phase;
    header_position_next = header_position;
    header_ok_next       = header_ok;
    tag_len_reg_next     = tag_len_reg;
    consumed_count_next  = consumed_count;
    current_id_next      = current_id;
    current_size_next    = current_size;
    payload_count_next   = payload_count;
    unique case (phase)
      PH_TAG_HDR: begin
        if (header_position == POS_ID0 && data_byte != CHAR_I) header_ok_next = 1'b0;
        if (header_position == POS_ID1 && data_byte != CHAR_D) header_ok_next = 1'b0;
        if (header_position == POS_ID2 && data_byte != CHAR_3) header_ok_next = 1'b0;
        if (header_position == POS_VERSION && data_byte != VERSION_MAJOR) begin
          header_ok_next = 1'b0;
        end
        if (header_position >= POS_TAG_LEN) begin
          tag_len_reg_next = {tag_len_reg[20:0], data_byte[6:0]};
        end
        if (header_position >= POS_HDR_LAST) begin
          header_position_next = '0;
          phase_next = header_ok ? PH_FRAME_HDR : PH_REJECT;
        end else begin
          header_position_next = header_position + 4'd1;
        end
      end
      PH_FRAME_HDR: begin
        if (start_past) begin
          phase_next = PH_PAST;
        end else begin
          current_size_next = size_base;
          if (header_position < POS_SIZE) begin
            current_id_next = {current_id[23:0], data_byte};
          end else if (header_position < POS_FLAGS) begin
            if (frame_size_mode) begin
              current_size_next = {size_base[24:0], data_byte[6:0]};
            end else begin
              current_size_next = {size_base[23:0], data_byte};
            end
          end
          if (header_position >= POS_HDR_LAST) begin
            consumed_count_next = (consumed_sum > {4'b0, CONSUMED_LIMIT}) ?
                                  CONSUMED_LIMIT : consumed_sum[28:0];
            header_position_next = '0;
            payload_count_next   = '0;
            phase_next = (current_size_next == 32'd0) ? PH_FRAME_HDR : PH_PAYLOAD;
          end else begin
            header_position_next = header_position + 4'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (last_payload) begin
          phase_next           = PH_FRAME_HDR;
          header_position_next = '0;
        end
        payload_count_next = payload_count + 32'd1;
      end
      PH_REJECT: begin
        phase_next = PH_REJECT;
      end
      default: begin
        phase_next = PH_PAST;
      end
    endcase
  end

  always_comb begin
    logic frame_fields;
    frame_fields = ((phase == PH_FRAME_HDR) && !start_past) || (phase == PH_PAYLOAD);
    result = '0;
    result.byte_value = data_byte;
    result.tag_length = tag_len_reg_next;
    unique case (phase)
      PH_TAG_HDR:   result.byte_kind = KIND_TAG_HDR;
      PH_FRAME_HDR: result.byte_kind = start_past ? KIND_PAST : KIND_FRAME_HDR;
      PH_PAYLOAD:   result.byte_kind = KIND_PAYLOAD;
      PH_REJECT:    result.byte_kind = KIND_REJECT;
      default:      result.byte_kind = KIND_PAST;
    endcase
    if (frame_fields) begin
      result.frame_name   = current_id_next;
      result.frame_length = current_size_next;
      result.text_frame   = (current_id_next[31:24] == CHAR_T);
    end
    if (phase == PH_PAYLOAD) begin
      result.payload_offset = payload_count;
      result.frame_end      = last_payload;
    end else if (phase == PH_FRAME_HDR && !start_past) begin
      result.frame_end = (header_position >= POS_HDR_LAST) && (current_size_next == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TAG_HDR;
      header_position <= '0;
      header_ok       <= 1'b1;
      tag_len_reg     <= '0;
      consumed_count  <= '0;
      current_id      <= '0;
      current_size    <= '0;
      payload_count   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      header_ok       <= header_ok_next;
      tag_len_reg     <= tag_len_reg_next;
      consumed_count  <= consumed_count_next;
      current_id      <= current_id_next;
      current_size    <= current_size_next;
      payload_count   <= payload_count_next;
    end
  end

endmodule

// File: src/id3v2_tag_frame_splitter_top.sv
// Top level of the ID3v2 tag frame splitter: input register, parser, result register.
//
// The block reads a file as a stream of bytes on the input channel (data_byte,
// in_valid, in_stall) and returns one item per byte on the output channel
// (byte_kind and the frame fields, out_valid, out_stall). An item moves on a
// channel at a rising edge where valid is high and stall is low.
// An accepted byte is held in the input register, is classified by the parser
// and then lands in the result register, where its item is shown until the
// receiver takes it. One byte is taken every cycle while the receiver does
// not stall; the parse state is updated once for each accepted byte.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more byte; only then is in_stall raised.
// The APB-style port holds frame_size_mode at address 0 (0 plain size,
// 1 syncsafe size); write it only while no item is in flight.
// Reset clears the valid flags of both pipeline registers, the register file
// and the parse state, so the next byte is taken as the first byte of a new tag header.
module id3v2_tag_frame_splitter_top import id3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_kind,
  output logic [7:0]  byte_value,
  output logic [31:0] frame_name,
  output logic [31:0] frame_length,
  output logic [31:0] payload_offset,
  output logic        frame_end,
  output logic        text_frame,
  output logic [27:0] tag_length
);

  logic       frame_size_mode;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       accept;
  result_t    result;
  result_t    out_q;

  id3_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .frame_size_mode (frame_size_mode)
  );

  id3_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .data_byte       (s1_byte),
    .frame_size_mode (frame_size_mode),
    .result          (result)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign byte_kind      = out_q.byte_kind;
  assign byte_value     = out_q.byte_value;
  assign frame_name     = out_q.frame_name;
  assign frame_length   = out_q.frame_length;
  assign payload_offset = out_q.payload_offset;
  assign frame_end      = out_q.frame_end;
  assign text_frame     = out_q.text_frame;
  assign tag_length     = out_q.tag_length;

  // The input side only stalls when a byte is waiting behind a blocked result.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a waiting byte");

  // A waiting byte moves to the result register as soon as the receiver takes the item.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_stall) |=> out_valid)
    else $error("pipeline dropped a waiting byte");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_kind <= KIND_REJECT))
    else $error("byte kind out of range");

  a_end_in_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |->
      (byte_kind == KIND_FRAME_HDR || byte_kind == KIND_PAYLOAD))
    else $error("frame end outside a frame");

  a_offset_in_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_offset != 32'd0) |-> (byte_kind == KIND_PAYLOAD))
    else $error("payload offset outside payload");

endmodule
